// ----- hw/rtl/dwsm_pkg.sv -----
// Package for the daily window schedule matcher.
// Holds the shared constants, register index codes and slot window types.
// No dependencies.
package dwsm_pkg;

    // Slot count and widths
    localparam int SLOTS      = 8;
    localparam int REG_SLOTS  = 8;   // slots backed by a configuration register
    localparam int SLOT_BITS  = 22;  // one slot inside a pair register
    localparam int MIN_W      = 11;  // start minute and duration fields
    localparam int SEC_W      = 17;  // seconds of day
    localparam int CNT_W      = 4;   // enabled slot count
    localparam int CFG_W      = 44;  // widest configuration register
    localparam int CFG_IDX_W  = 3;
    localparam int CTR_W      = 32;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TREE_N     = 1 << $clog2(2 * SLOTS);  // leaves of the min tree

    localparam logic [SEC_W-1:0] DAY_SECS    = 17'd86400;
    localparam logic [MIN_W-1:0] DAY_MINS    = 11'd1440;
    localparam logic [CTR_W-1:0] NO_BOUNDARY = 32'hFFFF_FFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_PAIR_0     = 3'd0,
        CFG_SLOT_PAIR_1     = 3'd1,
        CFG_SLOT_PAIR_2     = 3'd2,
        CFG_SLOT_PAIR_3     = 3'd3,
        CFG_ENABLED_COUNT   = 3'd4
    } cfg_reg_t;

    // One slot's window in seconds, prepared at configuration time
    typedef struct packed {
        logic [SEC_W-1:0] start_sec;
        logic [SEC_W-1:0] end_mod;     // end taken modulo one day
        logic             wrap;        // end lies past midnight
        logic             end_is_day;  // end lands exactly on midnight
    } slot_win_t;

    // Per-slot evaluation for one query
    typedef struct packed {
        logic             hit;
        logic [SEC_W-1:0] d_start;     // seconds to next start, 1..86400
        logic [SEC_W-1:0] d_end;       // seconds to next end, 1..86400
    } slot_eval_t;

endpackage

// ----- hw/rtl/dwsm_cfg.sv -----
// Configuration registers of the schedule matcher.
// Converts minute fields into second windows on write; depends on dwsm_pkg.
module dwsm_cfg
    import dwsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    output slot_win_t            slot_win [SLOTS],
    output logic [CNT_W-1:0]     slot_count
);

    // Minutes to a window in seconds: start mod one day, duration capped at one day
    function automatic slot_win_t calc_window(input logic [MIN_W-1:0] start_min,
                                              input logic [MIN_W-1:0] dur_min);
        logic [MIN_W-1:0] sm;
        logic [MIN_W-1:0] dm;
        logic [SEC_W-1:0] s;
        logic [SEC_W:0]   e;
        slot_win_t        w;
        sm = (start_min >= DAY_MINS) ? start_min - DAY_MINS : start_min;
        dm = (dur_min > DAY_MINS) ? DAY_MINS : dur_min;
        s  = SEC_W'(sm * 17'd60);
        e  = {1'b0, s} + (SEC_W+1)'(dm * 18'd60);
        w.start_sec  = s;
        w.wrap       = (e > {1'b0, DAY_SECS});
        w.end_is_day = (e == {1'b0, DAY_SECS});
        w.end_mod    = (e >= {1'b0, DAY_SECS}) ? SEC_W'(e - {1'b0, DAY_SECS}) : e[SEC_W-1:0];
        return w;
    endfunction

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Slot windows; slots past the register range stay empty at midnight
    for (genvar k = 0; k < SLOTS; k++) begin : g_slot
        if (k < REG_SLOTS) begin : g_reg
            slot_win_t win_reg;
            slot_win_t win_next;

            always_comb begin
                win_next = win_reg;
                if (cfg_wr_en && cfg_index == CFG_IDX_W'(k / 2)) begin
                    win_next = calc_window(cfg_wdata[(k % 2) * SLOT_BITS +: MIN_W],
                                           cfg_wdata[(k % 2) * SLOT_BITS + MIN_W +: MIN_W]);
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    win_reg <= '0;
                end else begin
                    win_reg <= win_next;
                end
            end

            assign slot_win[k] = win_reg;
        end else begin : g_const
            assign slot_win[k] = '0;
        end
    end

    // Enabled count, saturated at the slot count on write
    always_comb begin
        count_next = count_reg;
        if (cfg_wr_en && cfg_index == CFG_ENABLED_COUNT) begin
            count_next = (cfg_wdata[CNT_W-1:0] > CNT_W'(SLOTS)) ? CNT_W'(SLOTS)
                                                                : cfg_wdata[CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign slot_count = count_reg;

endmodule

// ----- hw/rtl/dwsm_slot.sv -----
// One slot's evaluator: inside test and seconds to its next start and end.
// Purely combinational; depends on dwsm_pkg.
module dwsm_slot
    import dwsm_pkg::*;
(
    input  logic [SEC_W-1:0] now,
    input  slot_win_t        win,
    output slot_eval_t       eval
);

    // Seconds until a point of the day; a point at the present counts as a day away
    function automatic logic [SEC_W-1:0] until_point(input logic [SEC_W-1:0] point,
                                                     input logic [SEC_W-1:0] t);
        return (point > t) ? point - t : DAY_SECS - t + point;
    endfunction

    logic after_start;
    logic before_end;

    assign after_start = (now >= win.start_sec);
    assign before_end  = (now < win.end_mod);

    always_comb begin
        if (win.wrap) begin
            eval.hit = after_start || before_end;
        end else begin
            eval.hit = after_start && (win.end_is_day || before_end);
        end
        eval.d_start = until_point(win.start_sec, now);
        eval.d_end   = until_point(win.end_mod, now);
    end

endmodule

// ----- hw/rtl/daily_window_schedule_matcher.sv -----
// Daily window schedule matcher, top level.
// Instantiates dwsm_cfg and dwsm_slot; depends on dwsm_pkg.
//
//  channel   direction  payload (low bit first)
//  s_axis    in         time_of_day[16:0], rtc_counter[48:17], zero pad to 56
//  m_axis    out        in_window[0], active_slot[3:1], next_boundary_count[35:4], pad to 40
//  cfg       in         cfg_wr_en, cfg_index, cfg_wdata[43:0], write only
//
// One query per cycle while the result side is not stalled. A query passes through
// the input register and then the result register, with the slot compare and min
// tree between them. Reset clears the pipeline and all slots.
// A stalled result holds and the input register still frees when it moves on.
module daily_window_schedule_matcher
    import dwsm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // query stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [55:0]          s_axis_tdata,   // time_of_day, rtc_counter
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [39:0]          m_axis_tdata    // in_window, active_slot, next_boundary_count
);

    slot_win_t        slot_win [SLOTS];
    slot_eval_t       slot_eval [SLOTS];
    logic [CNT_W-1:0] slot_count;

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [SEC_W-1:0] now_reg;
    logic [SEC_W-1:0] now_next;
    logic [CTR_W-1:0] counter_reg;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             in_window_reg;
    logic [2:0]       active_slot_reg;
    logic [CTR_W-1:0] next_count_reg;

    logic             out_ready;
    logic             in_move;
    logic [SEC_W-1:0] raw_time;

    logic [SEC_W-1:0]      leaf [TREE_N];
    logic [SEC_W-1:0]      node [1:2*TREE_N-1];
    logic                  any_hit;
    logic [SLOT_IDX_W-1:0] which;
    logic [CTR_W-1:0]      delta;

    dwsm_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .slot_win   (slot_win),
        .slot_count (slot_count)
    );

    // Handshake: the input register frees whenever the result register can load
    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign in_move       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    // Input register, time folded into one day on entry
    assign raw_time = s_axis_tdata[SEC_W-1:0];
    assign now_next = (raw_time >= DAY_SECS) ? raw_time - DAY_SECS : raw_time;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready) begin
            in_valid_next = 1'b1;
        end else if (in_move) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            now_reg     <= now_next;
            counter_reg <= s_axis_tdata[SEC_W +: CTR_W];
        end
    end

    // Slot evaluators, disabled slots feed all-ones into the min tree
    for (genvar k = 0; k < SLOTS; k++) begin : g_slot
        dwsm_slot u_slot (
            .now  (now_reg),
            .win  (slot_win[k]),
            .eval (slot_eval[k])
        );
        assign leaf[2*k]   = (CNT_W'(k) < slot_count) ? slot_eval[k].d_start : '1;
        assign leaf[2*k+1] = (CNT_W'(k) < slot_count) ? slot_eval[k].d_end   : '1;
    end
    for (genvar i = 2 * SLOTS; i < TREE_N; i++) begin : g_pad
        assign leaf[i] = '1;
    end

    // Min tree over all boundary deltas
    always_comb begin
        for (int i = 0; i < TREE_N; i++) begin
            node[TREE_N + i] = leaf[i];
        end
        for (int i = TREE_N - 1; i >= 1; i--) begin
            node[i] = (node[2*i] < node[2*i+1]) ? node[2*i] : node[2*i+1];
        end
    end

    // Lowest matching enabled slot
    always_comb begin
        any_hit = 1'b0;
        which   = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (slot_eval[k].hit && (CNT_W'(k) < slot_count)) begin
                any_hit = 1'b1;
                which   = SLOT_IDX_W'(k);
            end
        end
    end

    // Deltas are at least one second already; no slots means no boundary
    assign delta = (slot_count == '0) ? NO_BOUNDARY : CTR_W'(node[1]);

    // Result register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (in_move) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_move) begin
            in_window_reg   <= any_hit;
            active_slot_reg <= 3'(which);
            next_count_reg  <= counter_reg + delta;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, next_count_reg, active_slot_reg, in_window_reg};

    // A query taken in always reaches the input register
    a_in_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> in_valid_reg)
        else $error("accepted query lost before input register");

    // A held query waits while the result side is blocked
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_ready |=> in_valid_reg && $stable(now_reg))
        else $error("input register dropped a stalled query");

    // Stored time is always folded into one day
    a_now_range: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg |-> now_reg < DAY_SECS)
        else $error("time of day out of range in input register");

    // No match means slot index zero
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !in_window_reg |-> active_slot_reg == 3'd0)
        else $error("active slot set without a match");

endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for daily_window_schedule_matcher: directed table, then random phases.
// Results are checked against an in-bench window predictor. Depends on dwsm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
    import dwsm_pkg::*;

    localparam int unsigned MIN_SECS = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd5;  // first index with no register
    localparam int PHASE_ITEMS = 200;
    localparam int PHASES = 8;

    // Result fields, lowest bit first in m_axis_tdata
    typedef struct packed {
        logic [CTR_W-1:0]      next_boundary_count;
        logic [SLOT_IDX_W-1:0] active_slot;
        logic                  in_window;
    } match_t;

    // One row of the directed table: a register write or a query
    typedef struct {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic [SEC_W-1:0]     tod;
        logic [CTR_W-1:0]     ctr;
        bit                   typed;
        match_t               want;
    } step_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [55:0]          s_axis_tdata;   // time_of_day, rtc_counter
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;   // in_window, active_slot, next_boundary_count

    // Typed expectation that rides along with the presented transaction
    bit     held_typed;
    match_t held_want;

    // Bench copy of the slot setup
    logic [MIN_W-1:0] win_start [SLOTS];
    logic [MIN_W-1:0] win_length [SLOTS];
    logic [CNT_W-1:0] live_slots;

    match_t expected_matches[$];
    match_t want, got;
    int     mismatch_count = 0;
    bit     steady = 1'b0;

    daily_window_schedule_matcher u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Seconds from now to the next occurrence of point; a point at now is a day away
    function automatic int unsigned secs_until(int unsigned point, int unsigned now);
        return (point > now) ? point - now : DAY_SECS - now + point;
    endfunction

    function automatic match_t predict_match(logic [SEC_W-1:0] tod, logic [CTR_W-1:0] ctr);
        int unsigned now, n, best, s, e, e_mod, len;
        int k;
        match_t m;
        m = '0;
        best = NO_BOUNDARY;
        now = 32'(tod);
        if (now >= DAY_SECS) now -= DAY_SECS;
        n = (live_slots > SLOTS) ? SLOTS : live_slots;
        for (k = 0; k < n; k++) begin
            len = 32'((win_length[k] > DAY_MINS) ? DAY_MINS : win_length[k]);
            s = (win_start[k] % DAY_MINS) * MIN_SECS;
            e = s + len * MIN_SECS;
            // a window ending past midnight covers both ends of the day
            if (!m.in_window && ((e > DAY_SECS) ? (now >= s || now < e - DAY_SECS)
                                                : (now >= s && now < e))) begin
                m.in_window = 1'b1;
                m.active_slot = SLOT_IDX_W'(k);
            end
            e_mod = (e >= DAY_SECS) ? e - DAY_SECS : e;
            if (secs_until(s, now) < best) best = secs_until(s, now);
            if (secs_until(e_mod, now) < best) best = secs_until(e_mod, now);
        end
        if (best == 0) best = 1;
        m.next_boundary_count = ctr + best;
        return m;
    endfunction

    function automatic logic [CFG_W-1:0] pair_of(logic [MIN_W-1:0] s0, logic [MIN_W-1:0] d0,
                                                 logic [MIN_W-1:0] s1, logic [MIN_W-1:0] d1);
        return {d1, s1, d0, s0};
    endfunction

    function automatic logic [MIN_W-1:0] rand_start();
        return ($urandom_range(0, 9) == 0) ? MIN_W'($urandom_range(DAY_MINS, (1 << MIN_W) - 1))
                                           : MIN_W'($urandom_range(0, DAY_MINS - 1));
    endfunction

    function automatic logic [MIN_W-1:0] rand_length();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MIN_W'($urandom_range(DAY_MINS + 1, (1 << MIN_W) - 1));
            2: return DAY_MINS;
            3: return MIN_W'($urandom_range(0, DAY_MINS));
            default: return MIN_W'($urandom_range(1, 240));
        endcase
    endfunction

    function automatic step_t write_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        step_t r;
        r = '{default: '0};
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic step_t query_row(logic [SEC_W-1:0] tod, logic [CTR_W-1:0] ctr);
        step_t r;
        r = '{default: '0};
        r.tod = tod;
        r.ctr = ctr;
        return r;
    endfunction

    function automatic step_t known_row(logic [SEC_W-1:0] tod, logic [CTR_W-1:0] ctr,
                                        logic inw, logic [SLOT_IDX_W-1:0] slot,
                                        logic [CTR_W-1:0] nxt);
        step_t r;
        r = query_row(tod, ctr);
        r.typed = 1'b1;
        r.want = '{next_boundary_count: nxt, active_slot: slot, in_window: inw};
        return r;
    endfunction

    // Register write; the enable stays high until end_writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        int h, k;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        if (idx <= CFG_SLOT_PAIR_3) begin
            for (h = 0; h < 2; h++) begin
                k = idx * 2 + h;
                if (k < SLOTS) begin
                    win_start[k] = val[h * SLOT_BITS +: MIN_W];
                    win_length[k] = val[h * SLOT_BITS + MIN_W +: MIN_W];
                end
            end
        end else if (idx == CFG_ENABLED_COUNT) begin
            live_slots = val[CNT_W-1:0];
        end
    endtask

    task automatic end_writes();
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Stop sending and wait until every expected result is back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        held_typed <= 1'b0;
        @(posedge aclk);
        while (expected_matches.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic send_query(logic [SEC_W-1:0] tod, logic [CTR_W-1:0] ctr,
                              bit typed, match_t typed_want);
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, ctr, tod};
        held_typed <= typed;
        held_want <= typed_want;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Receiver backpressure
    always @(posedge aclk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 32);
    end

    // Record each accepted query, check each accepted result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_matches.push_back(held_typed ? held_want
                    : predict_match(s_axis_tdata[SEC_W-1:0], s_axis_tdata[SEC_W +: CTR_W]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = match_t'(m_axis_tdata[$bits(match_t)-1:0]);
                if (expected_matches.size() == 0) begin
                    $error("result transaction with nothing pending: %h", got);
                    mismatch_count++;
                end else begin
                    want = expected_matches.pop_front();
                    if (got.in_window !== want.in_window) begin
                        $error("in_window expected %0d actual %0d",
                               want.in_window, got.in_window);
                        mismatch_count++;
                    end
                    if (got.active_slot !== want.active_slot) begin
                        $error("active_slot expected %0d actual %0d",
                               want.active_slot, got.active_slot);
                        mismatch_count++;
                    end
                    if (got.next_boundary_count !== want.next_boundary_count) begin
                        $error("next_boundary_count expected %h actual %h",
                               want.next_boundary_count, got.next_boundary_count);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        step_t directed [27];
        int live_plan [PHASES];
        int p, i, k;
        int unsigned base;
        bit writing;
        logic [SEC_W-1:0] tod;
        logic [CTR_W-1:0] ctr;

        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_SLOT_PAIR_0;
        cfg_wdata <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        held_typed <= 1'b0;
        held_want <= '0;
        for (k = 0; k < SLOTS; k++) begin
            win_start[k] = '0;
            win_length[k] = '0;
        end
        live_slots = '0;
        writing = 1'b0;
        live_plan = '{8, 0, 15, 1, 8, 4, 0, 8};

        directed = '{
            // after reset nothing is enabled: no window, no boundary
            known_row(17'd0,      32'h0000_0000, 1'b0, 3'd0, 32'hFFFF_FFFF),
            known_row(17'd86399,  32'hFFFF_FFFF, 1'b0, 3'd0, 32'hFFFF_FFFE),
            known_row(17'd131071, 32'h0000_0001, 1'b0, 3'd0, 32'h0000_0000),
            // wrap past midnight; start past end of day; empty window
            write_row(CFG_SLOT_PAIR_0, pair_of(11'd1380, 11'd120, 11'd2047, 11'd0)),
            // oversized duration covers the day; plain one-hour window
            write_row(CFG_SLOT_PAIR_1, pair_of(11'd0, 11'd2047, 11'd600, 11'd60)),
            // window ending exactly at midnight; start of exactly one day
            write_row(CFG_SLOT_PAIR_2, pair_of(11'd1439, 11'd1, 11'd1440, 11'd30)),
            write_row(CFG_SLOT_PAIR_3, pair_of(11'd720, 11'd1440, 11'd100, 11'd5)),
            // count above the slot total
            write_row(CFG_ENABLED_COUNT, 44'd15),
            query_row(17'd0,      32'h0000_0000),
            query_row(17'd86399,  32'hFFFF_FFFF),
            query_row(17'd82800,  32'h1234_5678),
            query_row(17'd3599,   32'hFFFF_FFF0),
            query_row(17'd3600,   32'h0000_0000),
            query_row(17'd36420,  32'h8000_0000),
            query_row(17'd36000,  32'h7FFF_FFFF),
            query_row(17'd86340,  32'hFFFF_0000),
            query_row(17'd100000, 32'h0000_FFFF),
            query_row(17'd131071, 32'h5555_5555),
            query_row(17'd43200,  32'hAAAA_AAAA),
            write_row(CFG_SLOT_PAIR_0, 44'hFFF_FFFF_FFFF),
            write_row(CFG_ENABLED_COUNT, 44'd1),
            query_row(17'd36420,  32'h0000_0001),
            query_row(17'd36419,  32'h0000_0002),
            // a write to an index with no register changes nothing
            write_row(CFG_UNMAPPED, 44'hFFF_FFFF_FFFF),
            query_row(17'd36419,  32'h0000_0003),
            write_row(CFG_ENABLED_COUNT, 44'd0),
            known_row(17'd65536,  32'h0000_0001, 1'b0, 3'd0, 32'h0000_0000)
        };

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed[r]) begin
            if (directed[r].is_write) begin
                if (!writing) drain();
                write_reg(directed[r].reg_idx, directed[r].reg_val);
                writing = 1'b1;
            end else begin
                if (writing) end_writes();
                writing = 1'b0;
                send_query(directed[r].tod, directed[r].ctr, directed[r].typed, directed[r].want);
            end
        end

        // random phases, each with a fresh slot setup
        for (p = 0; p < PHASES; p++) begin
            drain();
            steady = (p == 4);
            write_reg(CFG_SLOT_PAIR_0, pair_of(rand_start(), rand_length(),
                                               rand_start(), rand_length()));
            write_reg(CFG_SLOT_PAIR_1, pair_of(rand_start(), rand_length(),
                                               rand_start(), rand_length()));
            write_reg(CFG_SLOT_PAIR_2, pair_of(rand_start(), rand_length(),
                                               rand_start(), rand_length()));
            write_reg(CFG_SLOT_PAIR_3, pair_of(rand_start(), rand_length(),
                                               rand_start(), rand_length()));
            write_reg(CFG_ENABLED_COUNT,
                      CFG_W'((p == 6) ? $urandom_range(0, 15) : live_plan[p]));
            write_reg(CFG_UNMAPPED + CFG_IDX_W'($urandom_range(0, 2)),
                      CFG_W'({$urandom, $urandom}));
            end_writes();
            for (i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 2 && i == PHASE_ITEMS / 2) drain();
                case ($urandom_range(0, 19))
                    0: tod = SEC_W'($urandom_range(DAY_SECS, (1 << SEC_W) - 1));
                    1, 2, 3, 4, 5: begin
                        // land on or next to a start or an end
                        k = $urandom_range(0, SLOTS - 1);
                        base = (win_start[k] % DAY_MINS) * MIN_SECS;
                        if ($urandom_range(0, 1))
                            base += ((win_length[k] > DAY_MINS) ? DAY_MINS : win_length[k])
                                    * MIN_SECS;
                        tod = SEC_W'((base + 2 * DAY_SECS + $urandom_range(0, 2) - 1)
                                     % DAY_SECS);
                    end
                    default: tod = SEC_W'($urandom_range(0, DAY_SECS - 1));
                endcase
                ctr = ($urandom_range(0, 9) == 0) ? NO_BOUNDARY - $urandom_range(0, 90000)
                                                  : $urandom;
                send_query(tod, ctr, 1'b0, '0);
            end
        end

        drain();
        steady = 1'b0;
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/dwsm_pkg.sv
hw/rtl/dwsm_cfg.sv
hw/rtl/dwsm_slot.sv
hw/rtl/daily_window_schedule_matcher.sv
tb/sv/testbench.sv
